/* design/hmsks_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hmsks_pkg: shared types and constants of the HID key and move sequencer
// Holds the event kinds, the HID key codes, the limits of the move split and
// the command record that passes from the front part to the back part.
// ----------------------------------------------------------------------------
package hmsks_pkg;

  // Field widths of the input and result transactions.
  localparam int KeyValueW = 13;
  localparam int MoveW     = 14;
  localparam int MagW      = 13;
  localparam int CodeW     = 9;
  localparam int DeltaW    = 9;
  localparam int CountW    = 6;
  localparam int DivisorW  = 7;

  // Default depth of the command queue between the front and back parts.
  localparam int CmdDepth = 2;

  // Move split limits.
  localparam logic signed [MoveW-1:0] MoveLimit = 14'sd8000;
  localparam logic [DivisorW-1:0]     MaxStep   = 7'd127;
  localparam logic [CountW-1:0]       CountCap  = 6'd62;

  // Reciprocal of the step size, rounded up. With a 20-bit shift the
  // multiply-and-shift gives the exact quotient for every 13-bit magnitude.
  localparam int RecipShift = 20;
  localparam int RecipW     = 14;
  localparam logic [RecipW-1:0] StepRecip =
    RecipW'(((1 << RecipShift) + int'(MaxStep) - 1) / int'(MaxStep));

  // Bit positions of the modifiers within the key value.
  localparam int CtrlBit  = 10;
  localparam int AltBit   = 11;
  localparam int ShiftBit = 12;

  // HID key codes.
  localparam logic [CodeW-1:0] KeyBase   = 9'd136;
  localparam logic [CodeW-1:0] CodeCtrl  = 9'd128;
  localparam logic [CodeW-1:0] CodeShift = 9'd129;
  localparam logic [CodeW-1:0] CodeAlt   = 9'd130;

  // Operation codes of an input transaction.
  typedef enum logic {
    OP_KEY   = 1'b0,
    OP_MOUSE = 1'b1
  } op_t;

  // Kinds of result event.
  typedef enum logic [1:0] {
    EV_PRESS   = 2'd0,
    EV_RELEASE = 2'd1,
    EV_MOVE    = 2'd2,
    EV_CLICK   = 2'd3
  } ev_kind_t;

  // Front part states.
  typedef enum logic [2:0] {
    F_IDLE,
    F_CNT,
    F_DX,
    F_DY,
    F_PUSH
  } front_state_t;

  // Back part phases.
  typedef enum logic [2:0] {
    PH_IDLE,
    PH_MOD_DN,
    PH_KEY_DN,
    PH_KEY_UP,
    PH_MOD_UP,
    PH_STEP,
    PH_RESID,
    PH_CLICK
  } back_ph_t;

  // Classified command as queued for the back part.
  // mods: bit 0 ctrl, bit 1 alt, bit 2 shift.
  typedef struct packed {
    logic                     is_mouse;
    logic [7:0]               key;
    logic [2:0]               mods;
    logic [CountW-1:0]        count;
    logic signed [DeltaW-1:0] step_x;
    logic signed [DeltaW-1:0] step_y;
    logic signed [DeltaW-1:0] res_x;
    logic signed [DeltaW-1:0] res_y;
  } cmd_t;

  // Divider request and response.
  typedef struct packed {
    logic                start;
    logic [MagW-1:0]     dividend;
    logic [DivisorW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                busy;
    logic                done;
    logic [MagW-1:0]     quot;
    logic [DivisorW-1:0] rem;
  } div_rsp_t;

endpackage

/* design/hmsks_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hmsks_div: iterative unsigned divider
// Restoring division, one quotient bit per cycle, working from the top
// dividend bit down; done is raised for one cycle with the result.
// ----------------------------------------------------------------------------
module hmsks_div (
  input  logic                clk,
  input  logic                rst_n,
  input  hmsks_pkg::div_req_t req,
  output hmsks_pkg::div_rsp_t rsp
);

  localparam int BitCntW = $clog2(hmsks_pkg::MagW);

  logic                              busy_r, busy_nxt;
  logic                              done_r, done_nxt;
  logic [BitCntW-1:0]                bit_r, bit_nxt;
  logic [hmsks_pkg::MagW-1:0]        dvd_r, dvd_nxt;
  logic [hmsks_pkg::DivisorW:0]      rem_r, rem_nxt;
  logic [hmsks_pkg::DivisorW-1:0]    dsr_r, dsr_nxt;
  logic [hmsks_pkg::DivisorW:0]      trial;
  logic                              fits;

  // One restoring step: shift in the next dividend bit and try to subtract.
  always_comb begin
    trial    = {rem_r[hmsks_pkg::DivisorW-1:0], dvd_r[hmsks_pkg::MagW-1]};
    fits     = (trial >= {1'b0, dsr_r});
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    bit_nxt  = bit_r;
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    if (req.start && !busy_r) begin
      busy_nxt = 1'b1;
      bit_nxt  = '0;
      dvd_nxt  = req.dividend;
      rem_nxt  = '0;
      dsr_nxt  = req.divisor;
    end else if (busy_r) begin
      rem_nxt = fits ? (trial - {1'b0, dsr_r}) : trial;
      dvd_nxt = {dvd_r[hmsks_pkg::MagW-2:0], fits};
      bit_nxt = bit_r + BitCntW'(1);
      if (bit_r == BitCntW'(hmsks_pkg::MagW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Control state is reset; the datapath needs none.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bit_r <= bit_nxt;
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.quot = dvd_r;
  assign rsp.rem  = rem_r[hmsks_pkg::DivisorW-1:0];

endmodule

/* design/hmsks_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hmsks_front: command intake and classification
// Accepts a command, saturates the moves and, for a mouse command, works out
// the step count by a reciprocal multiplication and the per-step move and the
// residual with the divider, then pushes one classified command into the queue.
// ----------------------------------------------------------------------------
module hmsks_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                push,
  output logic                                full,
  input  logic                                in_operation,
  input  logic [hmsks_pkg::KeyValueW-1:0]     in_key_value,
  input  logic signed [hmsks_pkg::MoveW-1:0]  in_move_x,
  input  logic signed [hmsks_pkg::MoveW-1:0]  in_move_y,
  output hmsks_pkg::div_req_t                 div_req,
  input  hmsks_pkg::div_rsp_t                 div_rsp,
  output logic                                q_push,
  output hmsks_pkg::cmd_t                     q_data,
  input  logic                                q_full
);

  localparam int ProdW = hmsks_pkg::MagW + hmsks_pkg::RecipW;
  localparam int QuoW  = ProdW - hmsks_pkg::RecipShift;

  hmsks_pkg::front_state_t           state_r, state_nxt;
  hmsks_pkg::cmd_t                   cmd_r, cmd_nxt;
  logic [hmsks_pkg::MagW-1:0]        mag_x_r, mag_x_nxt, mag_y_r, mag_y_nxt;
  logic [hmsks_pkg::MagW-1:0]        big_r, big_nxt;
  logic                              neg_x_r, neg_x_nxt, neg_y_r, neg_y_nxt;
  logic signed [hmsks_pkg::MoveW-1:0] sat_x, sat_y;
  logic [hmsks_pkg::MoveW-1:0]       abs_x, abs_y;
  logic [hmsks_pkg::MagW-1:0]        big;
  logic [ProdW-1:0]                  cnt_prod;
  logic [QuoW-1:0]                   cnt_quo;
  logic [hmsks_pkg::CountW-1:0]      cnt_c;
  logic [hmsks_pkg::DeltaW-1:0]      q_mag, r_sum;
  logic                              accept;

  // Saturate the incoming moves and take their magnitudes.
  always_comb begin
    if (in_move_x > hmsks_pkg::MoveLimit) begin
      sat_x = hmsks_pkg::MoveLimit;
    end else if (in_move_x < -hmsks_pkg::MoveLimit) begin
      sat_x = -hmsks_pkg::MoveLimit;
    end else begin
      sat_x = in_move_x;
    end
    if (in_move_y > hmsks_pkg::MoveLimit) begin
      sat_y = hmsks_pkg::MoveLimit;
    end else if (in_move_y < -hmsks_pkg::MoveLimit) begin
      sat_y = -hmsks_pkg::MoveLimit;
    end else begin
      sat_y = in_move_y;
    end
    abs_x = sat_x[hmsks_pkg::MoveW-1] ? -sat_x : sat_x;
    abs_y = sat_y[hmsks_pkg::MoveW-1] ? -sat_y : sat_y;
    big   = (abs_x > abs_y) ? abs_x[hmsks_pkg::MagW-1:0] : abs_y[hmsks_pkg::MagW-1:0];
  end

  // Capped step count from the registered larger magnitude, and the step and
  // residual magnitudes from the divider.
  always_comb begin
    cnt_prod = ProdW'(big_r) * ProdW'(hmsks_pkg::StepRecip);
    cnt_quo  = cnt_prod[ProdW-1:hmsks_pkg::RecipShift];
    if (cnt_quo > QuoW'(hmsks_pkg::CountCap)) begin
      cnt_c = hmsks_pkg::CountCap;
    end else begin
      cnt_c = cnt_quo[hmsks_pkg::CountW-1:0];
    end
    q_mag = {1'b0, div_rsp.quot[7:0]};
    r_sum = q_mag + {2'b00, div_rsp.rem};
  end

  assign accept = push && !full;

  // Sequencing of the step count, the two divisions and the queue push.
  always_comb begin
    state_nxt = state_r;
    cmd_nxt   = cmd_r;
    mag_x_nxt = mag_x_r;
    mag_y_nxt = mag_y_r;
    big_nxt   = big_r;
    neg_x_nxt = neg_x_r;
    neg_y_nxt = neg_y_r;
    div_req   = '0;
    q_push    = 1'b0;
    full      = (state_r != hmsks_pkg::F_IDLE);
    unique case (state_r)
      hmsks_pkg::F_IDLE: begin
        if (accept) begin
          cmd_nxt          = '0;
          cmd_nxt.key      = in_key_value[7:0];
          cmd_nxt.mods     = {in_key_value[hmsks_pkg::ShiftBit],
                              in_key_value[hmsks_pkg::AltBit],
                              in_key_value[hmsks_pkg::CtrlBit]};
          cmd_nxt.is_mouse = (in_operation == hmsks_pkg::OP_MOUSE);
          mag_x_nxt        = abs_x[hmsks_pkg::MagW-1:0];
          mag_y_nxt        = abs_y[hmsks_pkg::MagW-1:0];
          big_nxt          = big;
          neg_x_nxt        = sat_x[hmsks_pkg::MoveW-1];
          neg_y_nxt        = sat_y[hmsks_pkg::MoveW-1];
          if (in_operation == hmsks_pkg::OP_MOUSE) begin
            state_nxt = hmsks_pkg::F_CNT;
          end else begin
            state_nxt = hmsks_pkg::F_PUSH;
          end
        end
      end
      hmsks_pkg::F_CNT: begin
        cmd_nxt.count    = cnt_c;
        div_req.start    = 1'b1;
        div_req.dividend = mag_x_r;
        div_req.divisor  = {1'b0, cnt_c} + hmsks_pkg::DivisorW'(1);
        state_nxt        = hmsks_pkg::F_DX;
      end
      hmsks_pkg::F_DX: begin
        if (div_rsp.done) begin
          cmd_nxt.step_x   = neg_x_r ? -q_mag : q_mag;
          cmd_nxt.res_x    = neg_x_r ? -r_sum : r_sum;
          div_req.start    = 1'b1;
          div_req.dividend = mag_y_r;
          div_req.divisor  = {1'b0, cmd_r.count} + hmsks_pkg::DivisorW'(1);
          state_nxt        = hmsks_pkg::F_DY;
        end
      end
      hmsks_pkg::F_DY: begin
        if (div_rsp.done) begin
          cmd_nxt.step_y = neg_y_r ? -q_mag : q_mag;
          cmd_nxt.res_y  = neg_y_r ? -r_sum : r_sum;
          state_nxt      = hmsks_pkg::F_PUSH;
        end
      end
      hmsks_pkg::F_PUSH: begin
        if (!q_full) begin
          q_push    = 1'b1;
          state_nxt = hmsks_pkg::F_IDLE;
        end
      end
      default: begin
        state_nxt = hmsks_pkg::F_IDLE;
      end
    endcase
  end

  assign q_data = cmd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= hmsks_pkg::F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r   <= cmd_nxt;
    mag_x_r <= mag_x_nxt;
    mag_y_r <= mag_y_nxt;
    big_r   <= big_nxt;
    neg_x_r <= neg_x_nxt;
    neg_y_r <= neg_y_nxt;
  end

endmodule

/* design/hmsks_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hmsks_queue: command queue between front and back
// A small first-in first-out store of classified commands in flip-flops,
// so that the front part can classify the next command while the back part
// is still emitting events.
// ----------------------------------------------------------------------------
module hmsks_queue #(
  parameter int DEPTH = hmsks_pkg::CmdDepth
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  hmsks_pkg::cmd_t push_data,
  output logic            full,
  input  logic            pop,
  output hmsks_pkg::cmd_t pop_data,
  output logic            empty
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  hmsks_pkg::cmd_t   mem_r [DEPTH];
  logic [PtrW-1:0]   wr_r, wr_nxt, rd_r, rd_nxt;
  logic [CntW-1:0]   cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign full     = (cnt_r == CntW'(DEPTH));
  assign empty    = (cnt_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem_r[rd_r];

  // Pointer and fill count update.
  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wr_nxt = (wr_r == PtrW'(DEPTH - 1)) ? '0 : wr_r + PtrW'(1);
    end
    if (do_pop) begin
      rd_nxt = (rd_r == PtrW'(DEPTH - 1)) ? '0 : rd_r + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Storage write.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_r] <= push_data;
    end
  end

endmodule

/* design/hmsks_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hmsks_back: event sequencer
// Takes one classified command from the queue and emits its HID events into
// an output register that the consumer pops, one per cycle while it keeps popping.
// ----------------------------------------------------------------------------
module hmsks_back (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 q_empty,
  input  hmsks_pkg::cmd_t                      q_data,
  output logic                                 q_pop,
  output logic                                 empty,
  input  logic                                 pop,
  output logic [1:0]                           out_event_kind,
  output logic [hmsks_pkg::CodeW-1:0]          out_key_code,
  output logic signed [hmsks_pkg::DeltaW-1:0]  out_delta_x,
  output logic signed [hmsks_pkg::DeltaW-1:0]  out_delta_y,
  output logic                                 out_last
);

  hmsks_pkg::back_ph_t               ph_r, ph_nxt;
  hmsks_pkg::cmd_t                   ent_r, ent_nxt;
  logic [2:0]                        left_r, left_nxt;
  logic [hmsks_pkg::CountW-1:0]      cnt_r, cnt_nxt;
  logic                              ov_r, ov_nxt;
  hmsks_pkg::ev_kind_t               kind_r, e_kind;
  logic [hmsks_pkg::CodeW-1:0]       code_r, e_code;
  logic signed [hmsks_pkg::DeltaW-1:0] dx_r, dy_r, e_dx, e_dy;
  logic                              last_r, e_last;
  logic                              emit, slot_free;
  logic [2:0]                        low, left_clr;
  logic [hmsks_pkg::CodeW-1:0]       low_code, key_code;
  logic                              res_nz, ld_res_nz;

  assign slot_free = !ov_r || pop;
  assign key_code  = hmsks_pkg::KeyBase + {1'b0, ent_r.key};
  assign res_nz    = (ent_r.res_x != '0) || (ent_r.res_y != '0);
  assign ld_res_nz = (q_data.res_x != '0) || (q_data.res_y != '0);

  // Lowest modifier still to do, in the order ctrl, alt, shift.
  always_comb begin
    low      = left_r & (~left_r + 3'd1);
    left_clr = left_r & ~low;
    if (low[0]) begin
      low_code = hmsks_pkg::CodeCtrl;
    end else if (low[1]) begin
      low_code = hmsks_pkg::CodeAlt;
    end else begin
      low_code = hmsks_pkg::CodeShift;
    end
  end

  // Phase sequencer: loads a command, then emits one event per free slot.
  always_comb begin
    ph_nxt   = ph_r;
    ent_nxt  = ent_r;
    left_nxt = left_r;
    cnt_nxt  = cnt_r;
    q_pop    = 1'b0;
    emit     = 1'b0;
    e_kind   = hmsks_pkg::EV_PRESS;
    e_code   = '0;
    e_dx     = '0;
    e_dy     = '0;
    e_last   = 1'b0;
    unique case (ph_r)
      hmsks_pkg::PH_IDLE: begin
        if (!q_empty) begin
          q_pop    = 1'b1;
          ent_nxt  = q_data;
          cnt_nxt  = q_data.count;
          left_nxt = q_data.mods;
          if (q_data.is_mouse) begin
            if (q_data.count != '0) begin
              ph_nxt = hmsks_pkg::PH_STEP;
            end else if (ld_res_nz) begin
              ph_nxt = hmsks_pkg::PH_RESID;
            end else begin
              ph_nxt = hmsks_pkg::PH_CLICK;
            end
          end else if (q_data.mods != '0) begin
            ph_nxt = hmsks_pkg::PH_MOD_DN;
          end else begin
            ph_nxt = hmsks_pkg::PH_KEY_DN;
          end
        end
      end
      hmsks_pkg::PH_MOD_DN: begin
        if (slot_free) begin
          emit     = 1'b1;
          e_kind   = hmsks_pkg::EV_PRESS;
          e_code   = low_code;
          left_nxt = left_clr;
          if (left_clr == '0) begin
            ph_nxt = hmsks_pkg::PH_KEY_DN;
          end
        end
      end
      hmsks_pkg::PH_KEY_DN: begin
        if (slot_free) begin
          emit   = 1'b1;
          e_kind = hmsks_pkg::EV_PRESS;
          e_code = key_code;
          ph_nxt = hmsks_pkg::PH_KEY_UP;
        end
      end
      hmsks_pkg::PH_KEY_UP: begin
        if (slot_free) begin
          emit     = 1'b1;
          e_kind   = hmsks_pkg::EV_RELEASE;
          e_code   = key_code;
          e_last   = (ent_r.mods == '0);
          left_nxt = ent_r.mods;
          ph_nxt   = (ent_r.mods == '0) ? hmsks_pkg::PH_IDLE : hmsks_pkg::PH_MOD_UP;
        end
      end
      hmsks_pkg::PH_MOD_UP: begin
        if (slot_free) begin
          emit     = 1'b1;
          e_kind   = hmsks_pkg::EV_RELEASE;
          e_code   = low_code;
          e_last   = (left_clr == '0);
          left_nxt = left_clr;
          if (left_clr == '0) begin
            ph_nxt = hmsks_pkg::PH_IDLE;
          end
        end
      end
      hmsks_pkg::PH_STEP: begin
        if (slot_free) begin
          emit    = 1'b1;
          e_kind  = hmsks_pkg::EV_MOVE;
          e_dx    = ent_r.step_x;
          e_dy    = ent_r.step_y;
          cnt_nxt = cnt_r - hmsks_pkg::CountW'(1);
          if (cnt_r == hmsks_pkg::CountW'(1)) begin
            ph_nxt = res_nz ? hmsks_pkg::PH_RESID : hmsks_pkg::PH_CLICK;
          end
        end
      end
      hmsks_pkg::PH_RESID: begin
        if (slot_free) begin
          emit   = 1'b1;
          e_kind = hmsks_pkg::EV_MOVE;
          e_dx   = ent_r.res_x;
          e_dy   = ent_r.res_y;
          ph_nxt = hmsks_pkg::PH_CLICK;
        end
      end
      hmsks_pkg::PH_CLICK: begin
        if (slot_free) begin
          emit   = 1'b1;
          e_kind = hmsks_pkg::EV_CLICK;
          e_last = 1'b1;
          ph_nxt = hmsks_pkg::PH_IDLE;
        end
      end
      default: begin
        ph_nxt = hmsks_pkg::PH_IDLE;
      end
    endcase
  end

  // Output register occupancy.
  always_comb begin
    if (emit) begin
      ov_nxt = 1'b1;
    end else if (pop) begin
      ov_nxt = 1'b0;
    end else begin
      ov_nxt = ov_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r <= hmsks_pkg::PH_IDLE;
      ov_r <= 1'b0;
    end else begin
      ph_r <= ph_nxt;
      ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ent_r  <= ent_nxt;
    left_r <= left_nxt;
    cnt_r  <= cnt_nxt;
    if (emit) begin
      kind_r <= e_kind;
      code_r <= e_code;
      dx_r   <= e_dx;
      dy_r   <= e_dy;
      last_r <= e_last;
    end
  end

  assign empty          = !ov_r;
  assign out_event_kind = kind_r;
  assign out_key_code   = code_r;
  assign out_delta_x    = dx_r;
  assign out_delta_y    = dy_r;
  assign out_last       = last_r;

endmodule

/* design/hid_move_split_key_sequencer_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hid_move_split_key_sequencer_unit: HID key and mouse move sequencer
// Turns key commands into modifier, key press and release events, and mouse
// commands into a run of equal move steps, any residual move and a click.
//
//   Channel  Handshake           Payload
//   input    push / full         in_operation, in_key_value, in_move_x/y
//   result   empty / pop         out_event_kind, out_key_code,
//                                out_delta_x/y, out_last
//
// A key command passes the accept and push states of the front part; a mouse
// command passes the accept state, the step count state, both divisions and
// the push. The back part first loads a command, then emits one event per
// cycle while the consumer keeps popping: up to 8 events for a key, up to 64
// for a move. The command queue lets the front classify the next command
// meanwhile. Reset is synchronous and clears all control state; there is no
// memory to sweep. Holding off pop stalls the back part and, once the queue is
// full, the front; full stays high until the front has queued its command.
// ----------------------------------------------------------------------------
module hid_move_split_key_sequencer_unit #(
  parameter int CMD_DEPTH = hmsks_pkg::CmdDepth
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 push,
  output logic                                 full,
  input  logic                                 in_operation,
  input  logic [hmsks_pkg::KeyValueW-1:0]      in_key_value,
  input  logic signed [hmsks_pkg::MoveW-1:0]   in_move_x,
  input  logic signed [hmsks_pkg::MoveW-1:0]   in_move_y,
  output logic                                 empty,
  input  logic                                 pop,
  output logic [1:0]                           out_event_kind,
  output logic [hmsks_pkg::CodeW-1:0]          out_key_code,
  output logic signed [hmsks_pkg::DeltaW-1:0]  out_delta_x,
  output logic signed [hmsks_pkg::DeltaW-1:0]  out_delta_y,
  output logic                                 out_last
);

  hmsks_pkg::div_req_t div_req;
  hmsks_pkg::div_rsp_t div_rsp;
  hmsks_pkg::cmd_t     q_in, q_out;
  logic                q_push, q_full, q_pop, q_empty;

  // Divider for the per-axis step.
  hmsks_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // Front part: intake and classification.
  hmsks_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (push),
    .full         (full),
    .in_operation (in_operation),
    .in_key_value (in_key_value),
    .in_move_x    (in_move_x),
    .in_move_y    (in_move_y),
    .div_req      (div_req),
    .div_rsp      (div_rsp),
    .q_push       (q_push),
    .q_data       (q_in),
    .q_full       (q_full)
  );

  // Command queue between the two parts.
  hmsks_queue #(
    .DEPTH (CMD_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_out),
    .empty     (q_empty)
  );

  // Back part: event sequencing and output register.
  hmsks_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_empty        (q_empty),
    .q_data         (q_out),
    .q_pop          (q_pop),
    .empty          (empty),
    .pop            (pop),
    .out_event_kind (out_event_kind),
    .out_key_code   (out_key_code),
    .out_delta_x    (out_delta_x),
    .out_delta_y    (out_delta_y),
    .out_last       (out_last)
  );

`ifndef SYNTH
  // The front part never pushes into a full queue.
  assert property (@(posedge clk) disable iff (!rst_n) q_push |-> !q_full)
    else $error("command pushed into a full queue");

  // The divider is never started while a division is still running.
  assert property (@(posedge clk) disable iff (!rst_n) div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  // Once a transaction is taken the front part refuses the next one.
  assert property (@(posedge clk) disable iff (!rst_n) (push && !full) |=> full)
    else $error("front part ready directly after accepting a transaction");

  // A click always closes its command.
  assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_event_kind == hmsks_pkg::EV_CLICK) |-> out_last)
    else $error("click event without last");
`endif

endmodule

/* bench/hid_move_split_key_sequencer_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hid_move_split_key_sequencer_unit_tb: self-checking bench of the HID sequencer
// Key and mouse commands are pushed into the block while its event queue is
// popped, both sides idling at random. A scoreboard works out the events that
// each accepted command should cause and checks every popped event, field by
// field, against the oldest one still due. Directed corner cases come first,
// then random commands, with one long consumer hold-off that fills the block.
// ----------------------------------------------------------------------------
module hid_move_split_key_sequencer_unit_tb;

  import hmsks_pkg::*;

  localparam int RandomItems = 260;
  localparam int HoldAfter   = 40;
  localparam int HoldCycles  = 300;
  localparam int DrainCycles = 100;
  localparam int CycleLimit  = 500000;
  localparam int ReportLimit = 40;

  // One expected HID event.
  typedef struct {
    ev_kind_t                 kind;
    logic [CodeW-1:0]         code;
    logic signed [DeltaW-1:0] dx;
    logic signed [DeltaW-1:0] dy;
    logic                     last;
  } hid_report_t;

  // Works out the event burst of each accepted command and checks popped events.
  class hid_report_scoreboard;
    hid_report_t due_reports[$];
    int key_cmds;
    int mouse_cmds;
    int checked;
    int failures;
    int longest_burst;

    function int clip(int v, int lim);
      if (v > lim) return lim;
      if (v < -lim) return -lim;
      return v;
    endfunction

    function void add_report(ev_kind_t kind, logic [CodeW-1:0] code, int dx, int dy);
      hid_report_t r;
      r.kind = kind;
      r.code = code;
      r.dx   = dx[DeltaW-1:0];
      r.dy   = dy[DeltaW-1:0];
      r.last = 1'b0;
      due_reports.push_back(r);
    endfunction

    // Appends the events that one accepted command causes.
    function void note_command(op_t op, logic [KeyValueW-1:0] kv,
                               logic signed [MoveW-1:0] mx, logic signed [MoveW-1:0] my);
      int x, y, big, steps, sx, sy, rx, ry, i, start;
      logic [CodeW-1:0] key;
      hid_report_t tail;
      start = due_reports.size();
      if (op == OP_KEY) begin
        key_cmds++;
        key = KeyBase + {1'b0, kv[7:0]};
        // Modifier presses, the key itself, then modifier releases in the same order.
        if (kv[CtrlBit]) add_report(EV_PRESS, CodeCtrl, 0, 0);
        if (kv[AltBit]) add_report(EV_PRESS, CodeAlt, 0, 0);
        if (kv[ShiftBit]) add_report(EV_PRESS, CodeShift, 0, 0);
        add_report(EV_PRESS, key, 0, 0);
        add_report(EV_RELEASE, key, 0, 0);
        if (kv[CtrlBit]) add_report(EV_RELEASE, CodeCtrl, 0, 0);
        if (kv[AltBit]) add_report(EV_RELEASE, CodeAlt, 0, 0);
        if (kv[ShiftBit]) add_report(EV_RELEASE, CodeShift, 0, 0);
      end else begin
        mouse_cmds++;
        x = clip(int'(mx), int'(MoveLimit));
        y = clip(int'(my), int'(MoveLimit));
        big = (x < 0 ? -x : x);
        if ((y < 0 ? -y : y) > big) big = (y < 0 ? -y : y);
        steps = big / int'(MaxStep);
        if (steps > int'(CountCap)) steps = int'(CountCap);
        // Division on int truncates toward zero, as the step size needs.
        sx = x / (steps + 1);
        sy = y / (steps + 1);
        for (i = 0; i < steps; i++) add_report(EV_MOVE, '0, sx, sy);
        rx = clip(x - sx * steps, 255);
        ry = clip(y - sy * steps, 255);
        if (rx != 0 || ry != 0) add_report(EV_MOVE, '0, rx, ry);
        add_report(EV_CLICK, '0, 0, 0);
      end
      // Flag the final event of the burst.
      tail = due_reports[$];
      void'(due_reports.pop_back());
      tail.last = 1'b1;
      due_reports.push_back(tail);
      if (due_reports.size() - start > longest_burst) longest_burst = due_reports.size() - start;
    endfunction

    function void compare_field(string name, logic signed [15:0] want, logic signed [15:0] got);
      if (got !== want) begin
        failures++;
        if (failures <= ReportLimit)
          $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
    endfunction

    // Checks one popped event against the oldest one due.
    function void check_report(logic [1:0] kind, logic [CodeW-1:0] code,
                               logic signed [DeltaW-1:0] dx, logic signed [DeltaW-1:0] dy,
                               logic last);
      hid_report_t want;
      if (due_reports.size() == 0) begin
        failures++;
        if (failures <= ReportLimit)
          $display("%0t ns: event with none expected, expected nothing, actual kind %0d code %0d",
                   $time, kind, code);
        return;
      end
      want = due_reports.pop_front();
      checked++;
      compare_field("event_kind", {14'd0, want.kind}, {14'd0, kind});
      compare_field("key_code", {7'd0, want.code}, {7'd0, code});
      compare_field("delta_x", 16'(want.dx), 16'(dx));
      compare_field("delta_y", 16'(want.dy), 16'(dy));
      compare_field("last", {15'd0, want.last}, {15'd0, last});
    endfunction
  endclass

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     push = 1'b0;
  logic                     full;
  logic                     in_operation = 1'b0;
  logic [KeyValueW-1:0]     in_key_value = '0;
  logic signed [MoveW-1:0]  in_move_x = '0;
  logic signed [MoveW-1:0]  in_move_y = '0;
  logic                     empty;
  logic                     pop = 1'b0;
  logic [1:0]               out_event_kind;
  logic [CodeW-1:0]         out_key_code;
  logic signed [DeltaW-1:0] out_delta_x;
  logic signed [DeltaW-1:0] out_delta_y;
  logic                     out_last;

  bit steady = 1'b0;
  hid_report_scoreboard sb = new();

  hid_move_split_key_sequencer_unit i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (push),
    .full           (full),
    .in_operation   (in_operation),
    .in_key_value   (in_key_value),
    .in_move_x      (in_move_x),
    .in_move_y      (in_move_y),
    .empty          (empty),
    .pop            (pop),
    .out_event_kind (out_event_kind),
    .out_key_code   (out_key_code),
    .out_delta_x    (out_delta_x),
    .out_delta_y    (out_delta_y),
    .out_last       (out_last)
  );

  // Free-running clock, 10 ns period.
  always #5 clk = ~clk;

  // Offers one command and waits until the block takes the transaction.
  // Push is left high so that a following command goes straight on.
  // The moves are given as integers and sent as their low 14 bits.
  task automatic send_command(op_t op, logic [KeyValueW-1:0] kv, int mx, int my);
    logic signed [MoveW-1:0] vx;
    logic signed [MoveW-1:0] vy;
    vx = mx[MoveW-1:0];
    vy = my[MoveW-1:0];
    push         <= 1'b1;
    in_operation <= op;
    in_key_value <= kv;
    in_move_x    <= vx;
    in_move_y    <= vy;
    do @(posedge clk); while (full !== 1'b0);
    sb.note_command(op, kv, vx, vy);
  endtask

  // Random sender gap, now and then a long one that can span a whole division.
  task automatic pause_sender();
    if (!steady && $urandom_range(0, 99) < 20) begin
      push <= 1'b0;
      repeat ($urandom_range(0, 3) == 0 ? $urandom_range(10, 60) : $urandom_range(1, 5))
        @(posedge clk);
    end
  endtask

  // Move values: raw 14-bit patterns (saturation), short moves, and the legal range.
  function automatic int random_move();
    int v;
    logic signed [MoveW-1:0] m;
    case ($urandom_range(0, 3))
      0: v = int'($urandom);
      1: v = int'($urandom_range(0, 600)) - 300;
      default: v = int'($urandom_range(0, 16000)) - 8000;
    endcase
    m = v[MoveW-1:0];
    return int'(m);
  endfunction

  // Consumer: checks each popped event and pops at random, with one long hold-off.
  initial begin
    int  hold_left;
    bit  hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && pop && !empty)
        sb.check_report(out_event_kind, out_key_code, out_delta_x, out_delta_y, out_last);
      if (!hold_done && sb.key_cmds + sb.mouse_cmds >= HoldAfter) begin
        hold_left = HoldCycles;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else if (steady) begin
        pop <= 1'b1;
      end else begin
        pop <= ($urandom_range(0, 99) >= 20);
      end
    end
  end

  // Watchdog on the whole run.
  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk);
      cycles++;
    end
    $display("Timeout after %0d cycles with %0d events still due", cycles, sb.due_reports.size());
    $display("RESULT: ERROR");
    $finish;
  end

  // Stimulus: reset, directed corner cases, then random commands.
  initial begin
    int n;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Key commands: bare keys, each modifier, all of them, ignored bits and moves.
    send_command(OP_KEY, 13'h0000, 0, 0);                pause_sender();
    send_command(OP_KEY, 13'h1FFF, 0, 0);                pause_sender();
    send_command(OP_KEY, 13'h03FF, 0, 0);                pause_sender();
    send_command(OP_KEY, 13'h0441, 0, 0);                pause_sender();
    send_command(OP_KEY, 13'h0812, 0, 0);                pause_sender();
    send_command(OP_KEY, 13'h1005, 0, 0);                pause_sender();
    send_command(OP_KEY, 13'h0C80, 0, 0);                pause_sender();
    send_command(OP_KEY, 13'h141C, 5000, -7);            pause_sender();
    // Mouse commands: no move, unit moves, step boundaries, extremes, saturation.
    send_command(OP_MOUSE, 13'h1FFF, 0, 0);              pause_sender();
    send_command(OP_MOUSE, 13'h0000, 1, 0);              pause_sender();
    send_command(OP_MOUSE, 13'h0000, 0, -1);             pause_sender();
    send_command(OP_MOUSE, 13'h0000, 127, 0);            pause_sender();
    send_command(OP_MOUSE, 13'h0000, 126, -126);         pause_sender();
    send_command(OP_MOUSE, 13'h0000, 254, -381);         pause_sender();
    send_command(OP_MOUSE, 13'h0000, -127, 127);         pause_sender();
    send_command(OP_MOUSE, 13'h0000, 8000, 8000);        pause_sender();
    send_command(OP_MOUSE, 13'h0000, -8000, -8000);      pause_sender();
    send_command(OP_MOUSE, 13'h0A55, 8191, -8192);       pause_sender();
    send_command(OP_MOUSE, 13'h0000, 8001, -8001);       pause_sender();
    send_command(OP_MOUSE, 13'h0000, -7999, 40);         pause_sender();
    send_command(OP_MOUSE, 13'h0000, 3, 8000);           pause_sender();

    // Random commands, with a stretch where neither side idles.
    for (n = 0; n < RandomItems; n++) begin
      steady = (n >= 120 && n < 170);
      if ($urandom_range(0, 1) == 1)
        send_command(OP_MOUSE, KeyValueW'($urandom_range(0, 8191)),
                     random_move(), random_move());
      else
        send_command(OP_KEY, KeyValueW'($urandom_range(0, 8191)),
                     random_move(), random_move());
      pause_sender();
    end
    steady = 1'b0;
    push <= 1'b0;

    // Drain, then give the block time to show any stray event.
    while (sb.due_reports.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("Covered %0d key and %0d mouse commands, %0d events checked, longest burst %0d.",
             sb.key_cmds, sb.mouse_cmds, sb.checked, sb.longest_burst);
    $display("Mismatches and stray events: %0d.", sb.failures);
    if (sb.failures == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
